### rtl/bol_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bol_pkg: shared types and constants of the bounded ordered list
// Holds the request and response payloads, the command format passed from
// the front end to the back end, and the codes used by both.
// ----------------------------------------------------------------------------
package bol_pkg;

   localparam int CAPACITY    = 16;
   localparam int PRICE_WIDTH = 32;

   localparam int FUNC_W   = 3;
   localparam int POS_W    = 5;
   localparam int INDEX_W  = 5;
   localparam int STATUS_W = 2;

   // Count and cursor hold 0..CAPACITY, addresses 0..CAPACITY-1.
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CMP_W  = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [FUNC_W-1:0] FUNC_APPEND = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_SEARCH = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_HEAD   = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

   typedef struct packed {
      logic [FUNC_W-1:0]      func;
      logic [PRICE_WIDTH-1:0] price;
      logic [POS_W-1:0]       position;
   } req_type;

   typedef struct packed {
      logic [PRICE_WIDTH-1:0] value;
      logic [INDEX_W-1:0]     index;
      logic                   found;
      logic [STATUS_W-1:0]    status;
      logic                   last;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_INSERT,
      OP_READ,
      OP_SEARCH,
      OP_REPLY
   } op_type;

   typedef struct packed {
      op_type                 op;
      logic [PRICE_WIDTH-1:0] word;
      logic [CNT_W-1:0]       slot;
      logic [STATUS_W-1:0]    status;
   } cmd_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SHIFT,
      BK_READ,
      BK_SEARCH,
      BK_REPLY
   } bk_state_type;

endpackage

### rtl/bounded_ordered_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_ordered_list: ordered store of price words
// Appends, head and position inserts, first-match search and in-order
// readout over a list of up to CAPACITY words.
//
//   channel | direction | payload   | handshake
//   req     | in        | req_type  | req_valid / req_stall
//   rsp     | out       | rsp_type  | rsp_valid / rsp_stall
//
// A request is classified at intake and queued in a two-entry queue; the
// sequencer then dispatches it and, for an insert, moves each entry from
// the tail down to the slot up by one, places the new word and replies;
// for a readout, it emits one response per entry; for a search, it visits
// entries until a match or the tail; for a fixed reply, it emits one reply.
// The rate is set by the single write port and single read port of the
// entry memory. Reset clears the counts, queue pointers, sequencer state and
// response valid; the entries need no clearing. A stalled response holds the
// sequencer; intake continues until the queue fills.
// ----------------------------------------------------------------------------
module bounded_ordered_list import bol_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    q_full;
   logic    q_push;
   cmd_type q_push_cmd;
   logic    q_pop;
   logic    q_valid;
   cmd_type q_cmd;

   bol_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_cmd     (q_push_cmd)
   );

   bol_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (q_push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_cmd   (q_cmd)
   );

   bol_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_cmd     (q_cmd),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

### rtl/bol_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bol_front: request intake and classification
// Decides from its own copy of the entry count whether a request stores,
// reads, searches or only needs a fixed reply, and pushes the command.
// ----------------------------------------------------------------------------
module bol_front import bol_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   input  logic    q_full,
   output logic    q_push,
   output cmd_type q_cmd
);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CMP_W-1:0] pos_ext;
   logic [CMP_W-1:0] pos_limit;
   logic             full;
   logic             legal;
   logic             accept;

   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign pos_ext   = CMP_W'(req_data.position);
   assign pos_limit = CMP_W'(count_ff) + 1'b1;

   always_comb begin
      legal       = 1'b1;
      q_cmd.op     = OP_REPLY;
      q_cmd.word   = req_data.price;
      q_cmd.slot   = '0;
      q_cmd.status = ST_OK;
      count_in     = count_ff;
      case (req_data.func)
         FUNC_APPEND, FUNC_HEAD, FUNC_INSERT: begin
            if (full) begin
               q_cmd.status = ST_FULL;
            end else if (req_data.func == FUNC_INSERT &&
                         (pos_ext == '0 || pos_ext > pos_limit)) begin
               q_cmd.status = ST_RANGE;
            end else begin
               q_cmd.op = OP_INSERT;
               if (req_data.func == FUNC_APPEND) begin
                  q_cmd.slot = count_ff;
               end else if (req_data.func == FUNC_INSERT) begin
                  q_cmd.slot = CNT_W'(pos_ext - 1'b1);
               end
               count_in = count_ff + 1'b1;
            end
         end
         FUNC_READ: begin
            if (count_ff == '0) begin
               q_cmd.status = ST_EMPTY;
            end else begin
               q_cmd.op = OP_READ;
            end
         end
         FUNC_SEARCH: begin
            // An empty list answers with a plain not-found reply.
            if (count_ff != '0) begin
               q_cmd.op = OP_SEARCH;
            end
         end
         default: begin
            legal = 1'b0;
         end
      endcase
   end

   assign q_push = accept && legal;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (q_push) begin
         count_ff <= count_in;
      end
   end

endmodule

### rtl/bol_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bol_queue: command queue between front end and back end
// A small first-in first-out buffer so that each side can stall on its own.
// ----------------------------------------------------------------------------
module bol_queue import bol_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    pop_valid,
   output cmd_type pop_cmd
);

   cmd_type           slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] fill_ff;

   assign full      = (fill_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_valid = (fill_ff != '0);
   assign pop_cmd   = slots_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop && pop_valid) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !(pop && pop_valid)) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (!push && pop && pop_valid) begin
            fill_ff <= fill_ff - 1'b1;
         end
      end
   end

endmodule

### rtl/bol_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bol_back: list storage and command sequencer
// Holds the entries in a single-port-write memory, shifts entries for an
// insert one per cycle, walks the list for readout and search, and owns the
// response register.
// ----------------------------------------------------------------------------
module bol_back import bol_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_valid,
   input  cmd_type q_cmd,
   output logic    q_pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   bk_state_type state_ff, state_in;

   logic [PRICE_WIDTH-1:0] entries_ff [CAPACITY];
   logic [PRICE_WIDTH-1:0] rd_data_ff;
   logic [ADDR_W-1:0]      rd_addr;
   logic                   we;
   logic [ADDR_W-1:0]      wa;
   logic [PRICE_WIDTH-1:0] wd;

   cmd_type          cmd_ff, cmd_in;
   logic [CNT_W-1:0] cur_ff, cur_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] cur_next;

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   logic    emit;
   rsp_type emit_data;

   logic free;
   logic last_entry;
   logic hit;

   assign free       = !rsp_valid_ff || !rsp_stall;
   assign cur_next   = cur_ff + 1'b1;
   assign last_entry = (cur_next == count_ff);
   assign hit        = (rd_data_ff == cmd_ff.word);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               case (q_cmd.op)
                  OP_INSERT: state_in = BK_SHIFT;
                  OP_READ:   state_in = BK_READ;
                  OP_SEARCH: state_in = BK_SEARCH;
                  default:   state_in = BK_REPLY;
               endcase
            end
         end
         BK_SHIFT: begin
            if (cur_ff == cmd_ff.slot) begin
               state_in = BK_REPLY;
            end
         end
         BK_READ: begin
            if (free && last_entry) begin
               state_in = BK_IDLE;
            end
         end
         BK_SEARCH: begin
            if (free && (hit || last_entry)) begin
               state_in = BK_IDLE;
            end
         end
         BK_REPLY: begin
            if (free) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_comb begin
      q_pop     = 1'b0;
      cmd_in    = cmd_ff;
      cur_in    = cur_ff;
      count_in  = count_ff;
      we        = 1'b0;
      wa        = cur_ff[ADDR_W-1:0];
      wd        = rd_data_ff;
      emit      = 1'b0;
      emit_data = '0;
      case (state_ff)
         BK_IDLE: begin
            q_pop = q_valid;
            if (q_valid) begin
               cmd_in = q_cmd;
               cur_in = (q_cmd.op == OP_INSERT) ? count_ff : '0;
            end
         end
         BK_SHIFT: begin
            // Each cycle moves the entry below the cursor up by one; the
            // new word lands once the cursor reaches its slot.
            we = 1'b1;
            if (cur_ff == cmd_ff.slot) begin
               wd       = cmd_ff.word;
               count_in = count_ff + 1'b1;
            end else begin
               cur_in = cur_ff - 1'b1;
            end
         end
         BK_READ: begin
            if (free) begin
               emit            = 1'b1;
               emit_data.value = rd_data_ff;
               emit_data.index = INDEX_W'(cur_next);
               emit_data.last  = last_entry;
               if (!last_entry) begin
                  cur_in = cur_next;
               end
            end
         end
         BK_SEARCH: begin
            if (hit) begin
               if (free) begin
                  emit            = 1'b1;
                  emit_data.index = INDEX_W'(cur_next);
                  emit_data.found = 1'b1;
                  emit_data.last  = 1'b1;
               end
            end else if (last_entry) begin
               if (free) begin
                  emit           = 1'b1;
                  emit_data.last = 1'b1;
               end
            end else begin
               cur_in = cur_next;
            end
         end
         BK_REPLY: begin
            if (free) begin
               emit             = 1'b1;
               emit_data.status = cmd_ff.status;
               emit_data.last   = 1'b1;
            end
         end
         default: begin
            cur_in = cur_ff;
         end
      endcase
   end

   // The memory is read at the next cursor so the word under the current
   // cursor is ready in the read register; a shift reads one slot lower.
   assign rd_addr = (state_in == BK_SHIFT) ? ADDR_W'(cur_in - 1'b1) : cur_in[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (we) begin
         entries_ff[wa] <= wd;
      end
      rd_data_ff <= entries_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      cur_ff <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= emit_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_shift_cursor: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_SHIFT |-> cur_ff >= cmd_ff.slot && count_ff < CNT_W'(CAPACITY))
      else $error("shift cursor below target slot or store full");

   a_read_cursor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_READ || state_ff == BK_SEARCH) |-> cur_ff < count_ff)
      else $error("walk cursor past the tail");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit |-> !(rsp_valid_ff && rsp_stall))
      else $error("response overwritten while stalled");

   a_emit_ends: assert property (@(posedge clock) disable iff (reset)
      emit && emit_data.last |=> state_ff == BK_IDLE)
      else $error("final response did not end the command");

endmodule
